// File: hdl/cubic_bezier_path_stepper_defines.svh
// Assertion macros shared by the cubic Bezier path stepper RTL.
`ifndef CUBIC_BEZIER_PATH_STEPPER_DEFINES_SVH
`define CUBIC_BEZIER_PATH_STEPPER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CBZ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CBZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cbz_pkg.sv
// Shared types, constants and the multiply-accumulate program of the path stepper.
package cbz_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic CFG_FRAME_COUNT   = 1'b0;
  localparam logic CFG_ARRIVE_MARGIN = 1'b1;

  localparam logic [7:0] FRAME_COUNT_RST   = 8'd90;
  localparam logic [7:0] ARRIVE_MARGIN_RST = 8'd25;

  // Control point scale factors, Q0.16
  localparam logic [14:0] K_C1X = 15'd26214;
  localparam logic [14:0] K_C1Y = 15'd9830;
  localparam logic [14:0] K_C2X = 15'd19661;
  localparam logic [14:0] K_C2Y = 15'd1966;

  localparam logic [4:0] UOP_CTRL_LAST  = 5'd3;
  localparam logic [4:0] UOP_STEP_FIRST = 5'd4;
  localparam logic [4:0] UOP_LAST       = 5'd29;
  localparam logic [4:0] DIV_LAST       = 5'd23;

  localparam logic signed [12:0] COORD_MAX = 13'h0FFF;
  localparam logic signed [12:0] COORD_MIN = 13'h1000;

  typedef enum logic [3:0] {
    A_DX, A_DY, A_T, A_U, A_TT_LO, A_TT_HI, A_UU_LO, A_UU_HI,
    A_P0X, A_P0Y, A_P3X, A_P3Y, A_C1X, A_C1Y, A_C2X, A_C2Y
  } a_sel_e;

  typedef enum logic [3:0] {
    B_K1X, B_K1Y, B_K2X, B_K2Y, B_T, B_U, B_T3, B_U3,
    B_W0_LO, B_W0_HI, B_W1_LO, B_W1_HI, B_W2_LO, B_W2_HI, B_W3_LO, B_W3_HI
  } b_sel_e;

  typedef enum logic [1:0] {SH_0, SH_17, SH_25} sh_sel_e;

  typedef enum logic [3:0] {
    D_NONE, D_C1X, D_C1Y, D_C2X, D_C2Y, D_TT, D_UU,
    D_W0, D_W1, D_W2, D_W3, D_SX, D_SY
  } dest_e;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    sh_sel_e sh_sel;
    logic    clr;
    dest_e   dest;
  } uop_t;

  typedef struct packed {
    logic load;
    logic step_adv;
    logic div_run;
    logic prep;
    logic mac_en;
    uop_t uop;
    logic round;
  } dp_cmd_t;

  typedef struct packed {
    logic in_box;
  } dp_sts_t;

  // Ops 0..3 build the control points, 4..13 the Bernstein weights,
  // 14..29 the weighted sums per axis (each 49-bit weight in two limbs).
  function automatic uop_t uop_decode(input logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = '{A_DX,    B_K1X,   SH_0,  1'b1, D_C1X};
      5'd1:  u = '{A_DY,    B_K1Y,   SH_0,  1'b1, D_C1Y};
      5'd2:  u = '{A_DX,    B_K2X,   SH_0,  1'b1, D_C2X};
      5'd3:  u = '{A_DY,    B_K2Y,   SH_0,  1'b1, D_C2Y};
      5'd4:  u = '{A_T,     B_T,     SH_0,  1'b1, D_TT};
      5'd5:  u = '{A_U,     B_U,     SH_0,  1'b1, D_UU};
      5'd6:  u = '{A_TT_LO, B_T,     SH_0,  1'b1, D_NONE};
      5'd7:  u = '{A_TT_HI, B_T,     SH_17, 1'b0, D_W3};
      5'd8:  u = '{A_UU_LO, B_U,     SH_0,  1'b1, D_NONE};
      5'd9:  u = '{A_UU_HI, B_U,     SH_17, 1'b0, D_W0};
      5'd10: u = '{A_TT_LO, B_U3,    SH_0,  1'b1, D_NONE};
      5'd11: u = '{A_TT_HI, B_U3,    SH_17, 1'b0, D_W2};
      5'd12: u = '{A_UU_LO, B_T3,    SH_0,  1'b1, D_NONE};
      5'd13: u = '{A_UU_HI, B_T3,    SH_17, 1'b0, D_W1};
      5'd14: u = '{A_P0X,   B_W0_LO, SH_0,  1'b1, D_NONE};
      5'd15: u = '{A_P0X,   B_W0_HI, SH_25, 1'b0, D_NONE};
      5'd16: u = '{A_P3X,   B_W3_LO, SH_0,  1'b0, D_NONE};
      5'd17: u = '{A_P3X,   B_W3_HI, SH_25, 1'b0, D_NONE};
      5'd18: u = '{A_C2X,   B_W2_LO, SH_0,  1'b0, D_NONE};
      5'd19: u = '{A_C2X,   B_W2_HI, SH_25, 1'b0, D_NONE};
      5'd20: u = '{A_C1X,   B_W1_LO, SH_0,  1'b0, D_NONE};
      5'd21: u = '{A_C1X,   B_W1_HI, SH_25, 1'b0, D_SX};
      5'd22: u = '{A_P0Y,   B_W0_LO, SH_0,  1'b1, D_NONE};
      5'd23: u = '{A_P0Y,   B_W0_HI, SH_25, 1'b0, D_NONE};
      5'd24: u = '{A_P3Y,   B_W3_LO, SH_0,  1'b0, D_NONE};
      5'd25: u = '{A_P3Y,   B_W3_HI, SH_25, 1'b0, D_NONE};
      5'd26: u = '{A_C2Y,   B_W2_LO, SH_0,  1'b0, D_NONE};
      5'd27: u = '{A_C2Y,   B_W2_HI, SH_25, 1'b0, D_NONE};
      5'd28: u = '{A_C1Y,   B_W1_LO, SH_0,  1'b0, D_NONE};
      5'd29: u = '{A_C1Y,   B_W1_HI, SH_25, 1'b0, D_SY};
      default: u = '{A_DX,  B_K1X,   SH_0,  1'b1, D_NONE};
    endcase
    return u;
  endfunction

endpackage

// File: hdl/cbz_dp.sv
// Datapath: path registers, step divider, shared multiply-accumulate, rounding.
module cbz_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbz_pkg::dp_cmd_t    cmd_i,
  output cbz_pkg::dp_sts_t    sts_o,
  input  logic [7:0]          frame_count_i,
  input  logic [7:0]          arrive_margin_i,
  input  logic signed [12:0]  start_x_i,
  input  logic signed [12:0]  start_y_i,
  input  logic signed [12:0]  end_x_i,
  input  logic signed [12:0]  end_y_i,
  output logic signed [12:0]  pos_x_o,
  output logic signed [12:0]  pos_y_o
);
  import cbz_pkg::*;

  localparam logic signed [43:0] CTL_HALF = 44'sh8000;
  localparam logic signed [61:0] POS_HALF = 62'sh8000_0000_0000;

  function automatic logic signed [12:0] sat13(input logic signed [13:0] v);
    logic signed [12:0] r;
    if (v[13] != v[12]) begin
      r = v[13] ? COORD_MIN : COORD_MAX;
    end else begin
      r = $signed(v[12:0]);
    end
    return r;
  endfunction

  logic signed [12:0] p0x_q, p0y_q, p3x_q, p3y_q;
  logic signed [12:0] c1x_q, c1y_q, c2x_q, c2y_q;
  logic signed [13:0] dx_q, dy_q;
  logic [7:0]  fc, step_q, step_nx;
  logic [8:0]  step_inc;
  logic [23:0] div_num_q;
  logic [7:0]  div_rem_q;
  logic [16:0] div_quo_q;
  logic [8:0]  div_r2, div_diff;
  logic        div_ge;
  logic [16:0] t_q, u_q, u_nx;
  logic [17:0] t3_q, u3_q;
  logic signed [17:0] mul_a;
  logic [24:0] mul_b;
  logic signed [43:0] prod_q, ctl_sum;
  sh_sel_e     sh_q;
  logic        clr_q;
  dest_e       dest_q;
  logic        mac_v_q;
  logic signed [61:0] prod_ext, prod_sh, acc_q, acc_d;
  logic [33:0] tt_q, uu_q;
  logic [48:0] w0_q, w1_q, w2_q, w3_q;
  logic signed [61:0] sx_q, sy_q, rsx, rsy;
  logic signed [12:0] pos_x_q, pos_y_q;
  logic signed [14:0] margin, lo_x, hi_x, lo_y, hi_y, pxe, pye;

  // Zero frame count behaves as one
  assign fc       = (frame_count_i == 8'd0) ? 8'd1 : frame_count_i;
  assign step_inc = {1'b0, step_q} + 9'd1;
  assign step_nx  = (step_inc < {1'b0, fc}) ? step_inc[7:0] : fc;

  // Restoring division, one quotient bit per cycle
  assign div_r2   = {div_rem_q, div_num_q[23]};
  assign div_ge   = div_r2 >= {1'b0, fc};
  assign div_diff = div_r2 - {1'b0, fc};
  assign u_nx     = 17'h10000 - div_quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.step_adv) begin
      step_q <= step_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p0x_q <= start_x_i;
      p0y_q <= start_y_i;
      p3x_q <= end_x_i;
      p3y_q <= end_y_i;
      dx_q  <= 14'(end_x_i) - 14'(start_x_i);
      dy_q  <= 14'(end_y_i) - 14'(start_y_i);
    end
    if (cmd_i.step_adv) begin
      // numerator: step * 2^16 + fc / 2
      div_num_q <= {step_nx, 9'd0, fc[7:1]};
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (cmd_i.div_run) begin
      div_rem_q <= div_ge ? div_diff[7:0] : div_r2[7:0];
      div_num_q <= {div_num_q[22:0], 1'b0};
      div_quo_q <= {div_quo_q[15:0], div_ge};
    end
    if (cmd_i.prep) begin
      t_q  <= div_quo_q;
      u_q  <= u_nx;
      t3_q <= {1'b0, div_quo_q} + {div_quo_q, 1'b0};
      u3_q <= {1'b0, u_nx} + {u_nx, 1'b0};
    end
  end

  always_comb begin
    case (cmd_i.uop.a_sel)
      A_DX:    mul_a = 18'(dx_q);
      A_DY:    mul_a = 18'(dy_q);
      A_T:     mul_a = {1'b0, t_q};
      A_U:     mul_a = {1'b0, u_q};
      A_TT_LO: mul_a = {1'b0, tt_q[16:0]};
      A_TT_HI: mul_a = {1'b0, tt_q[33:17]};
      A_UU_LO: mul_a = {1'b0, uu_q[16:0]};
      A_UU_HI: mul_a = {1'b0, uu_q[33:17]};
      A_P0X:   mul_a = 18'(p0x_q);
      A_P0Y:   mul_a = 18'(p0y_q);
      A_P3X:   mul_a = 18'(p3x_q);
      A_P3Y:   mul_a = 18'(p3y_q);
      A_C1X:   mul_a = 18'(c1x_q);
      A_C1Y:   mul_a = 18'(c1y_q);
      A_C2X:   mul_a = 18'(c2x_q);
      A_C2Y:   mul_a = 18'(c2y_q);
      default: mul_a = '0;
    endcase
    case (cmd_i.uop.b_sel)
      B_K1X:   mul_b = {10'd0, K_C1X};
      B_K1Y:   mul_b = {10'd0, K_C1Y};
      B_K2X:   mul_b = {10'd0, K_C2X};
      B_K2Y:   mul_b = {10'd0, K_C2Y};
      B_T:     mul_b = {8'd0, t_q};
      B_U:     mul_b = {8'd0, u_q};
      B_T3:    mul_b = {7'd0, t3_q};
      B_U3:    mul_b = {7'd0, u3_q};
      B_W0_LO: mul_b = w0_q[24:0];
      B_W0_HI: mul_b = {1'b0, w0_q[48:25]};
      B_W1_LO: mul_b = w1_q[24:0];
      B_W1_HI: mul_b = {1'b0, w1_q[48:25]};
      B_W2_LO: mul_b = w2_q[24:0];
      B_W2_HI: mul_b = {1'b0, w2_q[48:25]};
      B_W3_LO: mul_b = w3_q[24:0];
      B_W3_HI: mul_b = {1'b0, w3_q[48:25]};
      default: mul_b = '0;
    endcase
  end

  // Stage one: registered product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_v_q <= 1'b0;
    end else begin
      mac_v_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      prod_q <= mul_a * $signed({1'b0, mul_b});
      sh_q   <= cmd_i.uop.sh_sel;
      clr_q  <= cmd_i.uop.clr;
      dest_q <= cmd_i.uop.dest;
    end
  end

  // Stage two: accumulate and write back
  assign prod_ext = 62'(prod_q);
  assign ctl_sum  = prod_q + CTL_HALF;

  always_comb begin
    case (sh_q)
      SH_0:    prod_sh = prod_ext;
      SH_17:   prod_sh = prod_ext <<< 17;
      SH_25:   prod_sh = prod_ext <<< 25;
      default: prod_sh = prod_ext;
    endcase
    acc_d = (clr_q ? 62'sd0 : acc_q) + prod_sh;
  end

  always_ff @(posedge clk_i) begin
    if (mac_v_q) begin
      acc_q <= acc_d;
      case (dest_q)
        D_C1X:   c1x_q <= ctl_sum[28:16];
        D_C1Y:   c1y_q <= ctl_sum[28:16];
        D_C2X:   c2x_q <= ctl_sum[28:16];
        D_C2Y:   c2y_q <= ctl_sum[28:16];
        D_TT:    tt_q  <= acc_d[33:0];
        D_UU:    uu_q  <= acc_d[33:0];
        D_W0:    w0_q  <= acc_d[48:0];
        D_W1:    w1_q  <= acc_d[48:0];
        D_W2:    w2_q  <= acc_d[48:0];
        D_W3:    w3_q  <= acc_d[48:0];
        D_SX:    sx_q  <= acc_d;
        D_SY:    sy_q  <= acc_d;
        default: ;
      endcase
    end
  end

  // Round the 48 fraction bits away, halves up, then saturate
  assign rsx = sx_q + POS_HALF;
  assign rsy = sy_q + POS_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (cmd_i.round) begin
      pos_x_q <= sat13(rsx[61:48]);
      pos_y_q <= sat13(rsy[61:48]);
    end
  end

  assign margin = $signed({7'd0, arrive_margin_i});
  assign pxe    = 15'(pos_x_q);
  assign pye    = 15'(pos_y_q);
  assign lo_x   = 15'(p3x_q) - margin;
  assign hi_x   = 15'(p3x_q) + margin;
  assign lo_y   = 15'(p3y_q) - margin;
  assign hi_y   = 15'(p3y_q) + margin;

  assign sts_o.in_box = (pxe >= lo_x) && (pxe <= hi_x) && (pye >= lo_y) && (pye <= hi_y);
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;

endmodule

// File: hdl/cbz_ctrl.sv
// Controller: sequences load, division, multiply-accumulate program and result hand-off.
module cbz_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic              out_free_i,
  input  cbz_pkg::dp_sts_t  sts_i,
  output cbz_pkg::dp_cmd_t  cmd_o,
  output logic              emit_o,
  output logic              moving_o,
  output logic              arrived_o
);
  import cbz_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CTRL  = 4'd1;
  localparam logic [3:0] ST_ADV   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_PREP  = 4'd4;
  localparam logic [3:0] ST_MAC   = 4'd5;
  localparam logic [3:0] ST_DRAIN = 4'd6;
  localparam logic [3:0] ST_ROUND = 4'd7;
  localparam logic [3:0] ST_CHECK = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       armed_q, armed_d;
  logic       fin_q, fin_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    fin_d     = fin_q;
    emit_o    = 1'b0;
    cmd_o     = '0;
    cmd_o.uop = uop_decode(cnt_q);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_START && !armed_q && !fin_q) begin
            cmd_o.load = 1'b1;
            armed_d    = 1'b1;
            cnt_d      = '0;
            state_d    = ST_CTRL;
          end else if (action_i == ACT_TICK && armed_q && !fin_q) begin
            state_d = ST_ADV;
          end else begin
            // nothing to do: repeat the current output
            state_d = ST_EMIT;
          end
        end
      end
      ST_CTRL: begin
        cmd_o.mac_en = 1'b1;
        if (cnt_q == UOP_CTRL_LAST) begin
          state_d = ST_ADV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_ADV: begin
        cmd_o.step_adv = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_PREP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = UOP_STEP_FIRST;
        state_d    = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (cnt_q == UOP_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.in_box) begin
          fin_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign moving_o   = armed_q && !fin_q;
  assign arrived_o  = fin_q;

endmodule

// File: hdl/cubic_bezier_path_stepper.sv
// Top level of the cubic Bezier path stepper: config registers, output register, core.
// A tick that steps advances the step, divides for t, runs the step ops, rounds and checks;
// a start item that arms the path builds the control points first; an ignored item re-emits.
// One item at a time, held longer while a result waits: t comes from a restoring divider
// and the curve from 26 ops on one shared 18x26 multiplier.
// Reset disarms the path, clears the step, position (0,0) and flags; frame_count 90, arrive_margin 25.
`include "cubic_bezier_path_stepper_defines.svh"

module cubic_bezier_path_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [12:0] start_x_i,
  input  logic signed [12:0] start_y_i,
  input  logic signed [12:0] end_x_i,
  input  logic signed [12:0] end_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [12:0] pos_x_o,
  output logic signed [12:0] pos_y_o,
  output logic               moving_o,
  output logic               arrived_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import cbz_pkg::*;

  logic [7:0]         frame_count_q, arrive_margin_q;
  logic               out_valid_q, moving_q, arrived_q;
  logic signed [12:0] pos_x_q, pos_y_q;
  logic               out_free, emit, flag_moving, flag_arrived;
  logic signed [12:0] dp_pos_x, dp_pos_y;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  // Configuration writes land directly; the user must issue them only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q   <= FRAME_COUNT_RST;
      arrive_margin_q <= ARRIVE_MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_COUNT:   frame_count_q   <= cfg_data_i;
        CFG_ARRIVE_MARGIN: arrive_margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The output slot may be refilled in the same cycle its transfer completes.
  assign out_free = !out_valid_q || out_ready_i;

  cbz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .emit_o     (emit),
    .moving_o   (flag_moving),
    .arrived_o  (flag_arrived)
  );

  cbz_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_count_i   (frame_count_q),
    .arrive_margin_i (arrive_margin_q),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .pos_x_o         (dp_pos_x),
    .pos_y_o         (dp_pos_y)
  );

  // Result register: hold until the transfer, decoupling the core from the sink.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_x_q   <= dp_pos_x;
      pos_y_q   <= dp_pos_y;
      moving_q  <= flag_moving;
      arrived_q <= flag_arrived;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign moving_o    = moving_q;
  assign arrived_o   = arrived_q;

  // Arrival is final until reset.
  `CBZ_ASSERT_NEXT(a_arrived_sticky, flag_arrived, flag_arrived, "arrival flag dropped")
  // A new result never overwrites one that has not been transferred.
  `CBZ_ASSERT_IMPL(a_no_overwrite, emit, out_free, "pending result overwritten")
  // A held result is never moving and arrived at once.
  `CBZ_ASSERT_IMPL(a_flags_exclusive, out_valid_q, !(moving_q && arrived_q), "moving and arrived")

endmodule

// File: test/tb_top.sv
// Testbench for the cubic Bezier path stepper: self-checking predictor with random handshakes.
module tb_top;
  import cbz_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Control point scales and t = 1, all Q0.16
  localparam longint SCALE_C1X = 26214;
  localparam longint SCALE_C1Y = 9830;
  localparam longint SCALE_C2X = 19661;
  localparam longint SCALE_C2Y = 1966;
  localparam longint T_ONE     = 65536;

  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic               moving;
    logic               arrived;
  } pos_rec_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               act;
  logic signed [12:0] start_x;
  logic signed [12:0] start_y;
  logic signed [12:0] end_x;
  logic signed [12:0] end_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [12:0] pos_x;
  logic signed [12:0] pos_y;
  logic               moving;
  logic               arrived;
  logic               cfg_we;
  logic               cfg_index;
  logic [7:0]         cfg_data;

  // Predicted block state, reset values
  logic [7:0]  m_frames = 8'd90;
  logic [7:0]  m_margin = 8'd25;
  int          org[2];
  int          dst[2];
  int          ctl_a[2];
  int          ctl_b[2];
  int          here[2];
  int unsigned steps;
  bit          live;
  bit          landed;

  pos_rec_t    expected_pos_q[$];

  int          err_cnt;
  bit          idle_on;
  int unsigned long_hold;
  int unsigned cycles;

  cubic_bezier_path_stepper u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (act),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .moving_o    (moving),
    .arrived_o   (arrived),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Round half toward plus infinity while dropping sh fraction bits
  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic int clamp13(input longint v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return int'(v);
  endfunction

  // Advance the step count, evaluate the curve and run the arrival box test
  task automatic path_advance();
    int unsigned fc;
    longint      t, u, s;
    longint      w[4];
    int          p;
    int          i;
    bit          in_box;
    fc = (m_frames == 8'd0) ? 1 : m_frames;
    steps = (steps + 1 < fc) ? steps + 1 : fc;
    t = (longint'(steps) * T_ONE + fc / 2) / fc;
    if (t > T_ONE) t = T_ONE;
    u = T_ONE - t;
    w[0] = u * u * u;
    w[1] = 3 * t * u * u;
    w[2] = 3 * t * t * u;
    w[3] = t * t * t;
    in_box = 1'b1;
    for (i = 0; i < 2; i++) begin
      s = longint'(org[i]) * w[0] + longint'(ctl_a[i]) * w[1]
        + longint'(ctl_b[i]) * w[2] + longint'(dst[i]) * w[3];
      p = clamp13(round_q(s, 48));
      here[i] = p;
      if (p < dst[i] - int'(m_margin) || p > dst[i] + int'(m_margin)) in_box = 1'b0;
    end
    if (in_box) landed = 1'b1;
  endtask

  // Apply one accepted item to the predicted state and queue the expected position
  task automatic path_apply(input logic a, input logic signed [12:0] sx,
                            input logic signed [12:0] sy, input logic signed [12:0] ex,
                            input logic signed [12:0] ey);
    pos_rec_t r;
    int       dx, dy;
    if (a == ACT_START) begin
      // a start only arms an idle block; busy or arrived paths drop it
      if (!live && !landed) begin
        org[0] = sx;
        org[1] = sy;
        dst[0] = ex;
        dst[1] = ey;
        dx = dst[0] - org[0];
        dy = dst[1] - org[1];
        ctl_a[0] = int'(round_q(longint'(dx) * SCALE_C1X, 16));
        ctl_a[1] = int'(round_q(longint'(dy) * SCALE_C1Y, 16));
        ctl_b[0] = int'(round_q(longint'(dx) * SCALE_C2X, 16));
        ctl_b[1] = int'(round_q(longint'(dy) * SCALE_C2Y, 16));
        steps = 0;
        live = 1'b1;
        path_advance();
      end
    end else if (live && !landed) begin
      path_advance();
    end
    r.x = 13'(here[0]);
    r.y = 13'(here[1]);
    r.moving = live && !landed;
    r.arrived = landed;
    expected_pos_q.push_back(r);
  endtask

  // Offer one item and hold it until the transfer; valid stays high for a back-to-back item
  task automatic send_item(input logic a, input logic [12:0] sx, input logic [12:0] sy,
                           input logic [12:0] ex, input logic [12:0] ey);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    act      <= a;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    path_apply(a, sx, sy, ex, ey);
  endtask

  task automatic send_random(input logic a);
    send_item(a, 13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pos_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic write_cfg(input logic [7:0] frames, input logic [7:0] margin);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_COUNT;
    cfg_data  <= frames;
    @(posedge clk);
    cfg_index <= CFG_ARRIVE_MARGIN;
    cfg_data  <= margin;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_frames = frames;
    m_margin = margin;
  endtask

  // Ticks before any start leave the block at the origin; cycle the register extremes
  task automatic test_before_arming();
    write_cfg(8'd255, 8'd0);
    send_item(ACT_TICK, 13'h1000, 13'h0FFF, 13'h0000, 13'h1FFF);
    write_cfg(8'd0, 8'd255);
    send_item(ACT_TICK, 13'h0FFF, 13'h1000, 13'h1FFF, 13'h0000);
    write_cfg(8'd1, 8'd128);
    send_item(ACT_TICK, 13'h1FFF, 13'h0000, 13'h1000, 13'h0FFF);
    write_cfg(8'd255, 8'd0);
  endtask

  // Arm the one path of the run across the full coordinate range, then try to restart it
  task automatic test_arm_path();
    send_item(ACT_START, 13'h1000, 13'h0FFF, 13'h0FFF, 13'h1000);
    send_item(ACT_START, 13'h0FFF, 13'h1000, 13'h1000, 13'h0FFF);
    send_item(ACT_START, 13'h0000, 13'h1FFF, 13'h0000, 13'h1FFF);
    repeat (3) send_random(ACT_TICK);
  endtask

  // Walk the path in phases; each phase picks a new frame count above the step count,
  // raising or lowering it mid path, and mixes in starts that a busy path must drop
  task automatic test_stepping(input int unsigned step_cap);
    int unsigned n;
    int unsigned lo;
    while (!landed && steps < step_cap) begin
      idle_on = ($urandom_range(0, 4) != 0);
      lo = steps + 10;
      write_cfg(8'($urandom_range(255, lo)), 8'($urandom_range(0, 20)));
      n = $urandom_range(1, 8);
      while (n != 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_random(ACT_START);
        end else begin
          send_random(ACT_TICK);
          n--;
        end
      end
    end
  endtask

  // Hold off the result side for a long stretch while ticks keep coming, so the input stalls
  task automatic test_receiver_hold();
    idle_on = 1'b0;
    write_cfg(8'd255, 8'd0);
    long_hold = 300;
    repeat (6) send_random(ACT_TICK);
  endtask

  // Frame count zero acts as one, so the next step lands on the end point
  task automatic test_arrival();
    idle_on = 1'b1;
    write_cfg(8'd0, 8'd255);
    send_random(ACT_TICK);
    // only reset can rearm an arrived path
    send_item(ACT_START, 13'h0000, 13'h0000, 13'h0FFF, 13'h0FFF);
    send_random(ACT_TICK);
  endtask

  // Random traffic against the arrived block; no idling over the last stretch
  task automatic test_after_arrival(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 60 == 59) write_cfg(8'($urandom), 8'($urandom));
      idle_on = (i < count - 200);
      send_random(1'($urandom));
    end
  endtask

  // Result side: ready with random stall bursts, or one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold != 0) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expected position
  always @(posedge clk) begin : check_results
    pos_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pos_q.size() == 0) begin
        if (err_cnt < 10)
          $display("%0t: result with nothing expected: pos (%0d,%0d) moving %0b arrived %0b",
                   $time, pos_x, pos_y, moving, arrived);
        err_cnt++;
      end else begin
        want = expected_pos_q.pop_front();
        if (pos_x !== want.x || pos_y !== want.y || moving !== want.moving ||
            arrived !== want.arrived) begin
          if (err_cnt < 10)
            $display("%0t: expected pos (%0d,%0d) moving %0b arrived %0b, got (%0d,%0d) %0b %0b",
                     $time, $signed(want.x), $signed(want.y), want.moving, want.arrived,
                     pos_x, pos_y, moving, arrived);
          err_cnt++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_valid  <= 1'b0;
    act       <= ACT_START;
    start_x   <= '0;
    start_y   <= '0;
    end_x     <= '0;
    end_y     <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FRAME_COUNT;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_arming();
    test_arm_path();
    test_stepping(120);
    test_receiver_hold();
    test_stepping(240);
    test_arrival();
    test_after_arrival(1000);

    // drain, then allow a full step latency for any stray result
    wait_idle();
    repeat (80) @(posedge clk);
    if (err_cnt == 0 && expected_pos_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
